/* rtl/core/ppaq_pkg.sv */
// Shared types and constants of the port pool allocator.
`default_nettype none
package ppaq_pkg;

  localparam int PORT_W   = 16;
  localparam int START_W  = 10;
  localparam int TIME_W   = 32;
  localparam int EXP_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_MARK    = 2'd2,
    REQ_TICK    = 2'd3
  } ppaq_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_PORT   = 2'd0,
    CFG_LAST_PORT    = 2'd1,
    CFG_HOLD_SECONDS = 2'd2,
    CFG_UNUSED       = 2'd3
  } ppaq_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_SCAN,
    ST_TICK,
    ST_DONE
  } ppaq_state_t;

  // One pool entry as held in the memory.
  typedef struct packed {
    logic              blocked;
    logic              free;
    logic [TIME_W-1:0] stamp;
  } ppaq_entry_t;

  localparam int ENTRY_W = $bits(ppaq_entry_t);

  // Configuration as seen by the request engine.
  typedef struct packed {
    logic [PORT_W-1:0] first_port;
    logic [PORT_W-1:0] last_port;
    logic [TIME_W-1:0] hold_seconds;
  } ppaq_cfg_t;

endpackage
`default_nettype wire

/* rtl/core/ppaq_if.sv */
// Handshake channel interfaces for requests, results and register writes.
`default_nettype none
interface ppaq_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic [ppaq_pkg::PORT_W-1:0]       port;
  logic [ppaq_pkg::START_W-1:0]      start_offset;
  logic [ppaq_pkg::TIME_W-1:0]       now_seconds;

  modport source (output valid, req_type, port, start_offset, now_seconds, input ready);
  modport sink   (input valid, req_type, port, start_offset, now_seconds, output ready);
endinterface

interface ppaq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ppaq_pkg::PORT_W-1:0]       granted_port;
  logic                              ok;
  logic [ppaq_pkg::EXP_W-1:0]        expired_count;

  modport source (output valid, granted_port, ok, expired_count, input ready);
  modport sink   (input valid, granted_port, ok, expired_count, output ready);
endinterface

interface ppaq_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ppaq_pkg::CFG_IDX_W-1:0]    index;
  logic [ppaq_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/port_pool_allocator_with_quarantine_unit.sv */
// Top level of the port pool allocator: configuration registers and request engine.
//
// Channel   Dir  Handshake      Payload
// in_req    in   valid/ready    req_type, port, start_offset, now_seconds
// out_rsp   out  valid/ready    granted_port, ok, expired_count
// cfg_wr    in   valid/ready    index, data (always ready)
//
// Release and mark write the addressed pool entry once decoded; acquire first
// reduces start_offset modulo the range size in the remainder unit, then reads the
// pool one entry per cycle until a free one is found or the range is exhausted.
// A tick sweeps all NUM_PORTS entries.
// After reset and after each write of first_port or last_port a clearing pass over
// all NUM_PORTS entries runs, during which no request is accepted.
// A new request is accepted while the previous result waits on out_rsp.
`default_nettype none
module port_pool_allocator_with_quarantine_unit #(
  parameter int NUM_PORTS = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ppaq_req_if.sink   in_req,
  ppaq_rsp_if.source out_rsp,
  ppaq_cfg_if.sink   cfg_wr
);

  logic [ppaq_pkg::PORT_W-1:0] first_r;
  logic [ppaq_pkg::PORT_W-1:0] last_r;
  logic [ppaq_pkg::TIME_W-1:0] hold_r;
  logic                        cfg_acc;
  logic                        clear_req;
  ppaq_pkg::ppaq_cfg_t         cfg;
  ppaq_pkg::ppaq_cfg_idx_t     cfg_idx;

  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid && cfg_wr.ready;
  assign cfg_idx      = ppaq_pkg::ppaq_cfg_idx_t'(cfg_wr.index);

  // Any change of the range bounds empties the pool.
  assign clear_req = cfg_acc && (cfg_idx == ppaq_pkg::CFG_FIRST_PORT ||
                                 cfg_idx == ppaq_pkg::CFG_LAST_PORT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 16'd0;
      last_r  <= 16'd1023;
      hold_r  <= 32'd3600;
    end else if (cfg_acc) begin
      unique case (cfg_idx)
        ppaq_pkg::CFG_FIRST_PORT:   first_r <= cfg_wr.data[ppaq_pkg::PORT_W-1:0];
        ppaq_pkg::CFG_LAST_PORT:    last_r  <= cfg_wr.data[ppaq_pkg::PORT_W-1:0];
        ppaq_pkg::CFG_HOLD_SECONDS: hold_r  <= cfg_wr.data[ppaq_pkg::TIME_W-1:0];
        ppaq_pkg::CFG_UNUSED:       ;
        default:                    ;
      endcase
    end
  end

  assign cfg.first_port   = first_r;
  assign cfg.last_port    = last_r;
  assign cfg.hold_seconds = hold_r;

  ppaq_seq #(
    .NUM_PORTS (NUM_PORTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .clear_req (clear_req),
    .req       (in_req),
    .rsp       (out_rsp)
  );

endmodule
`default_nettype wire

/* rtl/core/ppaq_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ppaq_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/ppaq_mod.sv */
// Iterative restoring remainder unit: start offset modulo the range size.
`default_nettype none
module ppaq_mod #(
  parameter int DIV_W = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ppaq_pkg::START_W-1:0]  dividend,
  input  wire logic [DIV_W-1:0]              divisor,
  output logic                               done,
  output logic      [DIV_W-1:0]              rem
);

  localparam int SW   = ppaq_pkg::START_W;
  localparam int RW   = ((DIV_W > SW) ? DIV_W : SW) + 1;
  localparam int CNTW = $clog2(SW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [SW-1:0]   dvd_r;
  logic [RW-1:0]   rem_r;
  logic [RW-1:0]   trial;
  logic [RW-1:0]   rem_nxt;

  // One dividend bit is shifted in per cycle, most significant first.
  assign trial   = {rem_r[RW-2:0], dvd_r[SW-1]};
  assign rem_nxt = (trial >= RW'(divisor)) ? (trial - RW'(divisor)) : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(SW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[SW-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem  = rem_r[DIV_W-1:0];

endmodule
`default_nettype wire

/* rtl/core/ppaq_seq.sv */
// Request engine: sequences clearing, acquire scans, releases, marks and expiry sweeps.
`default_nettype none
module ppaq_seq #(
  parameter int NUM_PORTS = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ppaq_pkg::ppaq_cfg_t cfg,
  input  wire logic                clear_req,
  ppaq_req_if.sink                 req,
  ppaq_rsp_if.source               rsp
);

  localparam int IW = $clog2(NUM_PORTS);
  localparam int CW = $clog2(NUM_PORTS + 1);
  localparam int PW = ppaq_pkg::PORT_W;
  localparam int TW = ppaq_pkg::TIME_W;
  localparam int EW = ppaq_pkg::EXP_W;

  ppaq_pkg::ppaq_state_t state_r, state_nxt;

  logic [CW-1:0]   size_r, size_nxt;
  logic [PW:0]     span;
  logic [CW-1:0]   iss_r, iss_nxt;
  logic [CW-1:0]   chk_r, chk_nxt;
  logic [IW-1:0]   ptr_r, ptr_nxt;
  logic            rvld_r, rvld_nxt;
  logic [IW-1:0]   raddr_r, raddr_nxt;
  logic [PW-1:0]   grant_r, grant_nxt;
  logic            ok_r, ok_nxt;
  logic [EW-1:0]   exp_r, exp_nxt;

  ppaq_pkg::ppaq_req_t req_r;
  logic [PW-1:0]   port_r;
  logic [ppaq_pkg::START_W-1:0] start_r;
  logic [TW-1:0]   now_r;

  logic            out_valid_r, out_valid_nxt;
  logic [PW-1:0]   out_grant_r;
  logic            out_ok_r;
  logic [EW-1:0]   out_exp_r;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  ppaq_pkg::ppaq_entry_t ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [ppaq_pkg::ENTRY_W-1:0] ram_rdata;
  ppaq_pkg::ppaq_entry_t rd_q;

  logic            mod_start;
  logic            mod_done;
  logic [CW-1:0]   mod_rem;

  logic [PW:0]     off;
  logic            in_rng;
  logic [IW-1:0]   idx;
  logic            hit;
  logic            scan_end;
  logic            scan_issue;
  logic            tick_issue;
  logic            tick_end;
  logic [TW-1:0]   due;
  logic            expire;
  logic            req_load;
  logic            out_load;

  // Clamped range size; an inverted range has no entries.
  assign span = {1'b0, cfg.last_port} - {1'b0, cfg.first_port} + (PW+1)'(1);
  always_comb begin
    if (cfg.last_port < cfg.first_port) begin
      size_nxt = '0;
    end else if (span > (PW+1)'(NUM_PORTS)) begin
      size_nxt = CW'(NUM_PORTS);
    end else begin
      size_nxt = CW'(span);
    end
  end

  assign off    = {1'b0, port_r} - {1'b0, cfg.first_port};
  assign in_rng = (port_r >= cfg.first_port) && (off < (PW+1)'(size_r));
  assign idx    = off[IW-1:0];

  assign rd_q       = ppaq_pkg::ppaq_entry_t'(ram_rdata);
  assign hit        = rvld_r && rd_q.free;
  assign scan_end   = rvld_r && !rd_q.free && (CW'(chk_r + CW'(1)) == size_r);
  assign scan_issue = (iss_r != size_r) && !hit;
  assign tick_issue = (iss_r != CW'(NUM_PORTS));
  assign tick_end   = rvld_r && (chk_r == CW'(NUM_PORTS - 1));
  assign due        = rd_q.stamp + cfg.hold_seconds;
  assign expire     = rd_q.blocked && (due < now_r);
  assign req_load   = (state_r == ppaq_pkg::ST_IDLE) && req.valid;
  assign out_load   = (state_r == ppaq_pkg::ST_DONE) && (!out_valid_r || rsp.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppaq_pkg::ST_CLEAR: begin
        if (iss_r == CW'(NUM_PORTS - 1)) state_nxt = ppaq_pkg::ST_IDLE;
      end
      ppaq_pkg::ST_IDLE: begin
        if (req.valid) state_nxt = ppaq_pkg::ST_DECODE;
      end
      ppaq_pkg::ST_DECODE: begin
        unique case (req_r)
          ppaq_pkg::REQ_ACQUIRE:
            state_nxt = (size_r == '0) ? ppaq_pkg::ST_DONE : ppaq_pkg::ST_MOD;
          ppaq_pkg::REQ_RELEASE: state_nxt = ppaq_pkg::ST_DONE;
          ppaq_pkg::REQ_MARK:    state_nxt = ppaq_pkg::ST_DONE;
          ppaq_pkg::REQ_TICK:    state_nxt = ppaq_pkg::ST_TICK;
          default:               state_nxt = ppaq_pkg::ST_DONE;
        endcase
      end
      ppaq_pkg::ST_MOD: begin
        if (mod_done) state_nxt = ppaq_pkg::ST_SCAN;
      end
      ppaq_pkg::ST_SCAN: begin
        if (hit || scan_end) state_nxt = ppaq_pkg::ST_DONE;
      end
      ppaq_pkg::ST_TICK: begin
        if (tick_end) state_nxt = ppaq_pkg::ST_DONE;
      end
      ppaq_pkg::ST_DONE: begin
        if (out_load) state_nxt = ppaq_pkg::ST_IDLE;
      end
      default: state_nxt = ppaq_pkg::ST_IDLE;
    endcase
    if (clear_req) state_nxt = ppaq_pkg::ST_CLEAR;
  end

  // Memory accesses, counters and result fields.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = raddr_r;
    ram_wdata  = rd_q;
    ram_raddr  = ptr_r;
    iss_nxt    = iss_r;
    chk_nxt    = chk_r;
    ptr_nxt    = ptr_r;
    rvld_nxt   = 1'b0;
    raddr_nxt  = raddr_r;
    grant_nxt  = grant_r;
    ok_nxt     = ok_r;
    exp_nxt    = exp_r;
    mod_start  = 1'b0;
    unique case (state_r)
      ppaq_pkg::ST_CLEAR: begin
        ram_we            = 1'b1;
        ram_waddr         = iss_r[IW-1:0];
        ram_wdata.blocked = 1'b0;
        ram_wdata.free    = 1'b1;
        ram_wdata.stamp   = '0;
        iss_nxt           = iss_r + CW'(1);
      end
      ppaq_pkg::ST_IDLE: begin
      end
      ppaq_pkg::ST_DECODE: begin
        grant_nxt = '0;
        ok_nxt    = 1'b0;
        exp_nxt   = '0;
        iss_nxt   = '0;
        chk_nxt   = '0;
        unique case (req_r)
          ppaq_pkg::REQ_ACQUIRE: mod_start = (size_r != '0);
          ppaq_pkg::REQ_RELEASE: begin
            if (in_rng) begin
              ram_we            = 1'b1;
              ram_waddr         = idx;
              ram_wdata.blocked = 1'b0;
              ram_wdata.free    = 1'b1;
              ram_wdata.stamp   = now_r;
              ok_nxt            = 1'b1;
            end
          end
          ppaq_pkg::REQ_MARK: begin
            if (in_rng) begin
              ram_we            = 1'b1;
              ram_waddr         = idx;
              ram_wdata.blocked = 1'b1;
              ram_wdata.free    = 1'b0;
              ram_wdata.stamp   = now_r;
              ok_nxt            = 1'b1;
            end
          end
          ppaq_pkg::REQ_TICK: ok_nxt = 1'b1;
          default: ;
        endcase
      end
      ppaq_pkg::ST_MOD: begin
        if (mod_done) ptr_nxt = mod_rem[IW-1:0];
      end
      ppaq_pkg::ST_SCAN: begin
        // The next read is issued while the previous entry is checked; none once a hit is seen.
        ram_raddr = ptr_r;
        rvld_nxt  = scan_issue;
        raddr_nxt = ptr_r;
        if (scan_issue) begin
          iss_nxt = iss_r + CW'(1);
          ptr_nxt = (CW'(ptr_r) + CW'(1) == size_r) ? '0 : ptr_r + IW'(1);
        end
        if (rvld_r) begin
          if (rd_q.free) begin
            ram_we         = 1'b1;
            ram_waddr      = raddr_r;
            ram_wdata.free = 1'b0;
            grant_nxt      = cfg.first_port + PW'(raddr_r);
            ok_nxt         = 1'b1;
          end else begin
            chk_nxt = chk_r + CW'(1);
          end
        end
      end
      ppaq_pkg::ST_TICK: begin
        ram_raddr = iss_r[IW-1:0];
        rvld_nxt  = tick_issue;
        raddr_nxt = iss_r[IW-1:0];
        if (tick_issue) iss_nxt = iss_r + CW'(1);
        if (rvld_r) begin
          chk_nxt = chk_r + CW'(1);
          if (expire) begin
            ram_we            = 1'b1;
            ram_waddr         = raddr_r;
            ram_wdata.blocked = 1'b0;
            ram_wdata.free    = 1'b1;
            exp_nxt           = exp_r + EW'(1);
          end
        end
      end
      ppaq_pkg::ST_DONE: begin
      end
      default: ;
    endcase
    if (clear_req) iss_nxt = '0;
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppaq_pkg::ST_CLEAR;
      iss_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    chk_r   <= chk_nxt;
    ptr_r   <= ptr_nxt;
    raddr_r <= raddr_nxt;
    grant_r <= grant_nxt;
    ok_r    <= ok_nxt;
    exp_r   <= exp_nxt;
    if (req_load) begin
      req_r   <= ppaq_pkg::ppaq_req_t'(req.req_type);
      port_r  <= req.port;
      start_r <= req.start_offset;
      now_r   <= req.now_seconds;
    end
    if (out_load) begin
      out_grant_r <= grant_r;
      out_ok_r    <= ok_r;
      out_exp_r   <= exp_r;
    end
  end

  assign req.ready         = (state_r == ppaq_pkg::ST_IDLE);
  assign rsp.valid         = out_valid_r;
  assign rsp.granted_port  = out_grant_r;
  assign rsp.ok            = out_ok_r;
  assign rsp.expired_count = out_exp_r;

  ppaq_ram #(
    .WIDTH (ppaq_pkg::ENTRY_W),
    .DEPTH (NUM_PORTS)
  ) u_pool_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ppaq_mod #(
    .DIV_W (CW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (start_r),
    .divisor  (size_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  a_rvld_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rvld_r |-> (state_r == ppaq_pkg::ST_SCAN || state_r == ppaq_pkg::ST_TICK))
    else $error("read data flagged valid outside a scan or sweep");

  a_chk_le_iss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppaq_pkg::ST_SCAN) |-> (chk_r <= iss_r))
    else $error("more entries checked than read");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppaq_pkg::ST_SCAN && rvld_r) |-> (CW'(raddr_r) < size_r))
    else $error("acquire scan touched an entry beyond the range");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppaq_pkg::ST_IDLE) |-> !ram_we)
    else $error("pool memory written while idle");

endmodule
`default_nettype wire
